>>> rtl/u8d_pkg.sv
// Package for the UTF-8 stream decoder: payload types, sizes and the offset table.
`timescale 1ns / 1ps
`default_nettype none
package u8d_pkg;

	localparam int COUNT_BITS_DEF  = 16;
	localparam int MAX_SEQ_LEN_DEF = 6;
	localparam int LEN_BITS        = 3;
	localparam int OUT_DEPTH       = 4;
	localparam int PTR_BITS        = $clog2(OUT_DEPTH);
	localparam int FILL_BITS       = $clog2(OUT_DEPTH + 1);

	localparam logic [7:0] CONT_MASK = 8'hc0;
	localparam logic [7:0] CONT_TAG  = 8'h80;
	localparam logic [7:0] END_BYTE  = 8'h00;

	typedef logic [LEN_BITS-1:0] seq_len_t;

	typedef struct packed {
		logic [7:0] text_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] code_point;
		logic        is_end;
		logic [15:0] char_total;
	} out_item_t;

	// Amount that the shift-add leaves above the code point, by sequence length minus one.
	function automatic logic [31:0] seq_offset(input seq_len_t idx);
		logic [31:0] r;
		case (idx)
			3'd0: r = 32'h0000_0000;
			3'd1: r = 32'h0000_3080;
			3'd2: r = 32'h000e_2080;
			3'd3: r = 32'h03c8_2080;
			3'd4: r = 32'hfa08_2080;
			3'd5: r = 32'h8208_2080;
			default: r = 32'h0000_0000;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/u8d_stream_if.sv
// Valid/ready stream interface carrying one payload of a given type.
`timescale 1ns / 1ps
`default_nettype none
interface u8d_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: sequence accumulator and result queue.
//
// channel   modport   payload                               direction
// text      sink      text_byte[7:0]                        byte requests in
// result    source    code_point[31:0] is_end char_total    results out
//
// One byte is taken every cycle; its results are in the result queue at the next edge.
// A terminator gives up to two results, every other byte at most one; the byte side
// stalls only while the four-entry result queue has fewer than two free places.
// The result side may stall at will; nothing is lost while it does.
// Reset clears the accumulator, the pending length, the count and the queue.
`timescale 1ns / 1ps
`default_nettype none
module utf8_stream_decoder #(
	parameter int COUNT_BITS  = u8d_pkg::COUNT_BITS_DEF,
	parameter int MAX_SEQ_LEN = u8d_pkg::MAX_SEQ_LEN_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	u8d_stream_if.sink         text,
	u8d_stream_if.source       result
);
	import u8d_pkg::*;

	logic [31:0]           acc_q;
	seq_len_t              pend_q;
	logic [COUNT_BITS-1:0] cnt_q;

	out_item_t             fifo_q [OUT_DEPTH];
	logic [PTR_BITS-1:0]   wr_q;
	logic [PTR_BITS-1:0]   rd_q;
	logic [FILL_BITS-1:0]  fill_q;

	logic                  take;
	logic                  pop;
	logic [7:0]            b;
	logic                  have_pend;
	logic                  append;
	logic [31:0]           flush_cp;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [31:0]           acc_d;
	seq_len_t              pend_d;
	logic [COUNT_BITS-1:0] cnt_d;
	out_item_t             item0;
	out_item_t             item1;
	logic [1:0]            n_push;

	assign text.ready   = (fill_q <= FILL_BITS'(OUT_DEPTH - 2));
	assign take         = text.valid && text.ready;
	assign result.valid = (fill_q != '0);
	assign result.data  = fifo_q[rd_q];
	assign pop          = result.valid && result.ready;

	assign b         = text.data.text_byte;
	assign have_pend = (pend_q != '0);
	assign append    = have_pend && ((b & CONT_MASK) == CONT_TAG)
		&& (pend_q < LEN_BITS'(MAX_SEQ_LEN));
	assign flush_cp  = acc_q - seq_offset(pend_q - seq_len_t'(1));
	assign cnt_inc   = (cnt_q != '1) ? cnt_q + COUNT_BITS'(1) : cnt_q;

	always_comb begin
		acc_d  = acc_q;
		pend_d = pend_q;
		cnt_d  = cnt_q;
		n_push = 2'd0;
		item0  = '{code_point: flush_cp, is_end: 1'b0,
			char_total: 16'(32'(cnt_inc))};
		item1  = '{code_point: 32'h0, is_end: 1'b1,
			char_total: 16'(32'(cnt_inc))};
		if (b == END_BYTE) begin
			acc_d  = '0;
			pend_d = '0;
			cnt_d  = '0;
			if (have_pend) begin
				n_push = 2'd2;
			end else begin
				n_push = 2'd1;
				item0  = '{code_point: 32'h0, is_end: 1'b1,
					char_total: 16'(32'(cnt_q))};
			end
		end else if (append) begin
			acc_d  = {acc_q[25:0], 6'b0} + {24'b0, b};
			pend_d = pend_q + seq_len_t'(1);
		end else begin
			acc_d  = {24'b0, b};
			pend_d = seq_len_t'(1);
			if (have_pend) begin
				n_push = 2'd1;
				cnt_d  = cnt_inc;
			end
		end
		if (!take) begin
			n_push = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pend_q <= '0;
			cnt_q  <= '0;
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (take) begin
				acc_q  <= acc_d;
				pend_q <= pend_d;
				cnt_q  <= cnt_d;
			end
			wr_q   <= wr_q + PTR_BITS'(n_push);
			if (pop) begin
				rd_q <= rd_q + PTR_BITS'(1);
			end
			fill_q <= fill_q + FILL_BITS'(n_push) - FILL_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			fifo_q[wr_q] <= item0;
		end
		if (n_push == 2'd2) begin
			fifo_q[wr_q + PTR_BITS'(1)] <= item1;
		end
	end

	// The queue never overfills, given the two-place margin on the byte side.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_BITS'(OUT_DEPTH))
		else $error("result queue overfilled");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= LEN_BITS'(MAX_SEQ_LEN))
		else $error("pending length beyond the longest sequence");

	// A terminator leaves nothing pending and the count at zero.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && (b == END_BYTE) |=> (pend_q == '0) && (cnt_q == '0))
		else $error("state not cleared after terminator");

	// Any other byte leaves a sequence pending.
	a_byte_pends: assert property (@(posedge clk) disable iff (!arst_n)
		take && (b != END_BYTE) |=> (pend_q != '0))
		else $error("byte accepted without a pending sequence");

endmodule
`default_nettype wire

>>> bench/tb_utf8_stream_decoder.sv
// Self-checking testbench for the UTF-8 stream decoder, with its own decoding predictor.
`timescale 1ns / 1ps
module tb_utf8_stream_decoder;
	import u8d_pkg::*;

	localparam int SEQ_MAX      = MAX_SEQ_LEN_DEF;
	localparam int CNT_BITS     = COUNT_BITS_DEF;
	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 11;
	localparam int PHASE_ITEMS  = 100;
	localparam int DRAIN_CYCLES = 16;
	localparam int STALL_LIMIT  = 4000;
	localparam int REPORT_MAX   = 40;

	localparam logic [CNT_BITS-1:0] COUNT_TOP = {CNT_BITS{1'b1}};

	// What the shift-add of a sequence leaves above its code point, by length minus one.
	localparam logic [31:0] LEAD_BIAS [0:5] = '{
		32'h0000_0000, 32'h0000_3080, 32'h000e_2080,
		32'h03c8_2080, 32'hfa08_2080, 32'h8208_2080
	};

	localparam logic LITERAL   = 1'b1;
	localparam logic PREDICTED = 1'b0;

	localparam out_item_t NO_RESULT = '0;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       literal;
		logic [1:0] n_lit;
		out_item_t  lit0;
		out_item_t  lit1;
	} stim_row_t;

	// Known answers are typed in only where they are obvious; other rows go through the predictor.
	localparam stim_row_t DIRECTED [24] = '{
		{END_BYTE, LITERAL, 2'd1, out_item_t'{32'h0, 1'b1, 16'd0}, NO_RESULT},
		{8'h41, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{END_BYTE, LITERAL, 2'd2, out_item_t'{32'h41, 1'b0, 16'd1},
			out_item_t'{32'h0, 1'b1, 16'd1}},
		{8'h7f, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'hc3, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'ha9, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'he2, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'h82, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'hac, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'hf0, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'h9f, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'h98, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'h80, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'hff, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{END_BYTE, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'h80, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'hfc, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'h80, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'hbf, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'h80, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'hbf, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'h80, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{8'hbf, PREDICTED, 2'd0, NO_RESULT, NO_RESULT},
		{END_BYTE, PREDICTED, 2'd0, NO_RESULT, NO_RESULT}
	};

	localparam int SEND_IDLE_PCT  [4] = '{0, 64, 0, 22};
	localparam int RECV_STALL_PCT [4] = '{0, 0, 64, 22};

	logic clk = 1'b0;
	logic arst_n;

	u8d_stream_if #(.T(in_item_t))  text_ch ();
	u8d_stream_if #(.T(out_item_t)) result_ch ();

	utf8_stream_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	logic [31:0]         pred_acc;
	logic [LEN_BITS-1:0] pred_len;
	logic [CNT_BITS-1:0] pred_count;
	out_item_t           pending_results [$];

	int send_idle;
	int recv_stall;
	int n_sent;
	int n_checked;
	int n_strings;
	int fail_count;
	int quiet_cycles;

	// Closes the sequence in progress, if there is one, counts it and, if record is set, records its code point.
	function automatic void close_sequence(input logic record);
		out_item_t r;
		if (pred_len != '0) begin
			if (pred_count != COUNT_TOP)
				pred_count++;
			r.code_point = pred_acc - LEAD_BIAS[pred_len - 1'b1];
			r.is_end     = 1'b0;
			r.char_total = pred_count[15:0];
			if (record)
				pending_results.push_back(r);
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic record);
		out_item_t r;
		if (b == END_BYTE) begin
			close_sequence(record);
			r.code_point = '0;
			r.is_end     = 1'b1;
			r.char_total = pred_count[15:0];
			if (record)
				pending_results.push_back(r);
			pred_acc   = '0;
			pred_len   = '0;
			pred_count = '0;
		end else if (pred_len != '0 && (b & CONT_MASK) == CONT_TAG && pred_len < SEQ_MAX) begin
			pred_acc = (pred_acc << 6) + b;
			pred_len++;
		end else begin
			close_sequence(record);
			pred_acc = {24'd0, b};
			pred_len = LEN_BITS'(1);
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic record);
		while ($urandom_range(99) < send_idle) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.data.text_byte <= b;
		do @(posedge clk); while (!text_ch.ready);
		n_sent++;
		decode_byte(b, record);
	endtask

	// One string: mostly well-formed characters, some noise, some damaged sequences.
	task automatic send_string();
		logic [7:0] text_buf [$];
		int kind;
		int n_chars;
		int seq_len;
		int n_cont;
		int pick;
		logic [7:0] lead;
		kind = $urandom_range(99);
		n_chars = $urandom_range(1, 6);
		for (int c = 0; c < n_chars; c++) begin
			if (kind >= 70 && kind < 85) begin
				text_buf.push_back(8'($urandom_range(1, 255)));
			end else begin
				pick = $urandom_range(99);
				seq_len = (pick < 40) ? 1 : (pick < 60) ? 2 : (pick < 75) ? 3 :
					(pick < 88) ? 4 : (pick < 94) ? 5 : 6;
				if (seq_len == 1) begin
					lead = 8'($urandom_range(1, 127));
				end else begin
					lead = 8'hff << (8 - seq_len);
					lead = lead | 8'($urandom_range(0, (1 << (7 - seq_len)) - 1));
				end
				text_buf.push_back(lead);
				n_cont = seq_len - 1;
				if (kind >= 85) begin
					// Damaged: drop some continuation bytes or add extra ones past the sequence length.
					if ($urandom_range(1) == 1)
						n_cont = $urandom_range(0, n_cont);
					else
						n_cont = n_cont + $urandom_range(1, 8);
				end
				for (int k = 0; k < n_cont; k++)
					text_buf.push_back(8'h80 | 8'($urandom_range(0, 63)));
			end
		end
		if ($urandom_range(9) != 0)
			text_buf.push_back(END_BYTE);
		foreach (text_buf[i])
			send_byte(text_buf[i], 1'b1);
		n_strings++;
	endtask

	task automatic note_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (fail_count < REPORT_MAX)
			$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
		fail_count++;
	endtask

	always @(posedge clk) begin
		result_ch.ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin : result_check
		out_item_t got;
		out_item_t want;
		got = result_ch.data;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				if (fail_count < REPORT_MAX)
					$error("unexpected result: code_point 0x%0h is_end %0b char_total %0d",
						got.code_point, got.is_end, got.char_total);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.code_point !== want.code_point)
					note_mismatch("code_point", want.code_point, got.code_point);
				if (got.is_end !== want.is_end)
					note_mismatch("is_end", 32'(want.is_end), 32'(got.is_end));
				if (got.char_total !== want.char_total)
					note_mismatch("char_total", 32'(want.char_total), 32'(got.char_total));
				n_checked++;
			end
		end
	end

	// Ends the run if neither channel moves a request for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no request moved for %0d cycles", quiet_cycles);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int phase_start;
		stim_row_t row;
		arst_n = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.data = '0;
		result_ch.ready = 1'b0;
		send_idle = 0;
		recv_stall = 0;
		n_sent = 0;
		n_checked = 0;
		n_strings = 0;
		fail_count = 0;
		quiet_cycles = 0;
		pred_acc = '0;
		pred_len = '0;
		pred_count = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			row = DIRECTED[i];
			if (row.literal) begin
				send_byte(row.text_byte, 1'b0);
				pending_results.push_back(row.lit0);
				if (row.n_lit == 2'd2)
					pending_results.push_back(row.lit1);
			end else begin
				send_byte(row.text_byte, 1'b1);
			end
		end

		for (int p = 0; p < 4; p++) begin
			send_idle = SEND_IDLE_PCT[p];
			recv_stall = RECV_STALL_PCT[p];
			phase_start = n_sent;
			while (n_sent - phase_start < PHASE_ITEMS)
				send_string();
			send_byte(END_BYTE, 1'b1);
		end
		text_ch.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes (%0d random strings), checked %0d results;", n_sent,
			n_strings, n_checked);
		$display("covered overlong runs, stray continuations, empty strings and all pacings.");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> utf8_stream_decoder.f
rtl/u8d_pkg.sv
rtl/u8d_stream_if.sv
rtl/utf8_stream_decoder.sv
bench/tb_utf8_stream_decoder.sv
